>>> rtl/core/vlp_pkg.sv
`timescale 1ns / 1ps
package vlp_pkg;

    localparam int MaxChunks     = 64;
    localparam int TilesPerChunk = 64;
    localparam int SlotW         = 6;
    localparam int TileW         = 6;
    localparam int AddrW         = SlotW + TileW;
    localparam int LinkDepth     = MaxChunks * 6;
    localparam int LinkAw        = $clog2(LinkDepth);
    localparam int CountW        = 7;
    localparam int ClearLen      = MaxChunks * TilesPerChunk;

    typedef enum logic [2:0] {
        KIND_WRITE_TILE = 3'd0,
        KIND_WRITE_LINK = 3'd1,
        KIND_DECAY      = 3'd2,
        KIND_SPREAD     = 3'd3,
        KIND_READ       = 3'd4
    } t_kind;

    typedef struct packed {
        logic [2:0]       kind;
        logic [SlotW-1:0] chunk_slot;
        logic [TileW-1:0] tile_index;
        logic [7:0]       light_level;
        logic             is_transparent;
        logic [2:0]       side;
        logic [SlotW-1:0] linked_chunk;
    } t_in_word;

    typedef struct packed {
        logic [7:0] light_out;
        logic [7:0] render_out;
    } t_out_word;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_HOST,
        OP_DECAY,
        OP_SP_LOAD,
        OP_SP_FACE,
        OP_SP_WRITE
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [AddrW-1:0] addr;
        logic [2:0]       face;
    } t_cmd;

    typedef struct packed {
        logic transparent;
    } t_status;

endpackage

>>> rtl/core/vlp_datapath.sv
`timescale 1ns / 1ps
module vlp_datapath
    import vlp_pkg::*;
(
    input  logic      i_clk,
    input  t_cmd      i_cmd,
    input  t_in_word  i_word,
    output t_status   o_status,
    output t_out_word o_data
);

    logic [7:0]        light_mem  [ClearLen];
    logic [7:0]        render_mem [ClearLen];
    logic              transp_mem [ClearLen];
    logic [SlotW-1:0]  link_mem   [LinkDepth];

    logic [7:0]       r_light;
    logic [7:0]       r_render;
    logic             r_transp;
    logic [7:0]       r_best;
    logic [7:0]       r_nbr;
    logic             r_nbr_ok;
    logic [SlotW-1:0] r_link;
    logic [AddrW-1:0] r_dec_addr;
    logic             r_dec_wr;

    logic [SlotW-1:0] slot;
    logic [TileW-1:0] tile;
    logic [1:0]       coord;
    logic             at_edge;
    logic [TileW-1:0] nb_in;
    logic [TileW-1:0] nb_out;
    logic [AddrW-1:0] nb_addr;
    logic [LinkAw-1:0] link_addr;
    logic [LinkAw-1:0] host_link_addr;
    logic [7:0]       n_best;

    assign slot  = i_cmd.addr[AddrW-1:TileW];
    assign tile  = i_cmd.addr[TileW-1:0];
    assign coord = (i_cmd.face[2:1] == 2'd0) ? tile[1:0] :
                   (i_cmd.face[2:1] == 2'd1) ? tile[3:2] : tile[5:4];
    assign at_edge = i_cmd.face[0] ? (coord == 2'd3) : (coord == 2'd0);
    assign link_addr = LinkAw'(slot * 6 + i_cmd.face);
    assign host_link_addr = LinkAw'(i_word.chunk_slot * 6 + i_word.side);

    always_comb begin
        unique case (i_cmd.face)
            3'd0: begin nb_in = tile - 6'd1;  nb_out = tile + 6'd3;  end
            3'd1: begin nb_in = tile + 6'd1;  nb_out = tile - 6'd3;  end
            3'd2: begin nb_in = tile - 6'd4;  nb_out = tile + 6'd12; end
            3'd3: begin nb_in = tile + 6'd4;  nb_out = tile - 6'd12; end
            3'd4: begin nb_in = tile - 6'd16; nb_out = tile + 6'd48; end
            default: begin nb_in = tile + 6'd16; nb_out = tile - 6'd48; end
        endcase
    end

    // Link read is registered, so the edge-case address uses the prior cycle's link.
    assign nb_addr = at_edge ? {r_link, nb_out} : {slot, nb_in};
    assign n_best = (r_nbr_ok && ({1'b0, r_nbr[7:1]} > r_best)) ? {1'b0, r_nbr[7:1]} : r_best;

    always_ff @(posedge i_clk) begin
        r_light  <= light_mem[i_cmd.addr];
        r_render <= render_mem[i_cmd.addr];
        r_transp <= transp_mem[i_cmd.addr];
        // Decay writes back in the cycle after the read, from the registered light.
        r_dec_wr   <= (i_cmd.op == OP_DECAY);
        r_dec_addr <= i_cmd.addr;
        if (r_dec_wr) begin
            render_mem[r_dec_addr] <= r_light;
            light_mem[r_dec_addr]  <= {1'b0, r_light[7:1]};
        end
        unique case (i_cmd.op)
            OP_CLEAR: begin
                light_mem[i_cmd.addr]  <= '0;
                render_mem[i_cmd.addr] <= '0;
                transp_mem[i_cmd.addr] <= 1'b0;
                if (i_cmd.addr < AddrW'(LinkDepth)) begin
                    link_mem[LinkAw'(i_cmd.addr)] <= '0;
                end
            end
            OP_HOST: begin
                if (i_word.kind == KIND_WRITE_TILE) begin
                    light_mem[i_cmd.addr]  <= i_word.light_level;
                    transp_mem[i_cmd.addr] <= i_word.is_transparent;
                end else if (i_word.kind == KIND_WRITE_LINK && i_word.side < 3'd6) begin
                    link_mem[host_link_addr] <= i_word.linked_chunk;
                end
            end
            OP_SP_LOAD: begin
                r_best   <= light_mem[i_cmd.addr];
                r_nbr_ok <= 1'b0;
                r_link   <= link_mem[link_addr];
            end
            OP_SP_FACE: begin
                r_best   <= n_best;
                r_nbr    <= render_mem[nb_addr];
                r_nbr_ok <= !at_edge || r_link != '0;
                r_link   <= link_mem[LinkAw'(slot * 6 + (i_cmd.face + 3'd1) % 8)];
            end
            OP_SP_WRITE: begin
                light_mem[i_cmd.addr] <= n_best;
            end
            default: begin
            end
        endcase
    end

    assign o_status.transparent = r_transp;
    assign o_data.light_out  = r_light;
    assign o_data.render_out = r_render;

endmodule

>>> rtl/core/vlp_controller.sv
`timescale 1ns / 1ps
module vlp_controller
    import vlp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  t_in_word          i_word,
    input  logic [CountW-1:0] i_count,
    input  t_status           i_status,
    output logic              busy,
    output logic              o_strobe,
    output logic              o_is_read,
    output t_cmd              o_cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_HOST, ST_DECAY, ST_SP_CHECK, ST_SP_FACE, ST_SP_WRITE
    } t_state;

    t_state           r_state;
    logic [AddrW:0]   r_addr;
    logic [2:0]       r_face;
    logic [SlotW:0]   r_lim;
    logic             r_strobe;
    logic             r_is_read;
    logic [AddrW:0]   end_addr;

    assign end_addr = {r_lim, {TileW{1'b0}}};

    always_comb begin
        o_cmd.addr = r_addr[AddrW-1:0];
        o_cmd.face = r_face;
        unique case (r_state)
            ST_CLEAR:    o_cmd.op = OP_CLEAR;
            ST_HOST:     o_cmd.op = OP_HOST;
            ST_DECAY:    o_cmd.op = OP_DECAY;
            ST_SP_CHECK: o_cmd.op = OP_SP_LOAD;
            ST_SP_FACE:  o_cmd.op = OP_SP_FACE;
            ST_SP_WRITE: o_cmd.op = OP_SP_WRITE;
            default:     o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_addr    <= '0;
            r_face    <= '0;
            r_lim     <= '0;
            r_strobe  <= 1'b0;
            r_is_read <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == (AddrW+1)'(ClearLen - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (start) begin
                        r_lim  <= (i_count > CountW'(MaxChunks)) ? (SlotW+1)'(MaxChunks)
                                                                 : (SlotW+1)'(i_count);
                        r_is_read <= i_word.kind == KIND_READ;
                        r_face <= '0;
                        if (i_word.kind == KIND_DECAY || i_word.kind == KIND_SPREAD) begin
                            r_addr <= (AddrW+1)'(TilesPerChunk);
                            if (i_count <= 1) begin
                                r_strobe <= 1'b1;
                            end else begin
                                r_state <= (i_word.kind == KIND_DECAY) ? ST_DECAY
                                                                        : ST_SP_CHECK;
                            end
                        end else begin
                            r_addr  <= {1'b0, i_word.chunk_slot, i_word.tile_index};
                            r_state <= ST_HOST;
                        end
                    end
                end
                ST_HOST: begin
                    r_strobe <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                ST_DECAY: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr + 1'b1 == end_addr) begin
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                ST_SP_CHECK: begin
                    // Light/transparency are valid the cycle after the address.
                    r_face  <= '0;
                    r_state <= ST_SP_FACE;
                end
                ST_SP_FACE: begin
                    if (r_face == 3'd0 && !i_status.transparent) begin
                        r_addr <= r_addr + 1'b1;
                        if (r_addr + 1'b1 == end_addr) begin
                            r_strobe <= 1'b1;
                            r_state  <= ST_IDLE;
                        end else begin
                            r_state <= ST_SP_CHECK;
                        end
                    end else if (r_face == 3'd5) begin
                        r_state <= ST_SP_WRITE;
                    end else begin
                        r_face <= r_face + 1'b1;
                    end
                end
                ST_SP_WRITE: begin
                    r_addr <= r_addr + 1'b1;
                    r_face <= '0;
                    if (r_addr + 1'b1 == end_addr) begin
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_state <= ST_SP_CHECK;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign busy      = r_state != ST_IDLE;
    assign o_strobe  = r_strobe;
    assign o_is_read = r_is_read;

endmodule

>>> rtl/core/voxel_light_propagation.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Word
// command   in         start & !busy           i_word (t_in_word)
// result    out        o_strobe, one cycle     o_word (t_out_word)
// config    in         i_cfg_valid & ready     i_cfg_data, chunk count
//
// Writes, reads and unknown kinds go through ST_HOST and then strobe; the next word is taken
// at the edge ending the strobe cycle. A pass with a count of 0 or 1 strobes next cycle.
// A decay pass does one tile per cycle over chunks 1 to min(count,64)-1, then strobes.
// Spread skips opaque tiles; transparent ones take all six faces, then a write-back.
// After reset all 4096 addresses of the memories are swept clear with busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.
module voxel_light_propagation
    import vlp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in_word          i_word,
    output logic              o_strobe,
    output t_out_word         o_word,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CountW-1:0] i_cfg_data
);

    logic [CountW-1:0] r_count;
    t_in_word          r_word;
    t_cmd              cmd;
    t_status           status;
    t_out_word         data;
    logic              is_read;

    assign o_cfg_ready = 1'b1;

    // The accepted word is held here, since the sender may change i_word
    // while the datapath is still working on it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CountW'(1);
            r_word  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end
            if (start && !busy) begin
                r_word <= i_word;
            end
        end
    end

    vlp_controller u_ctrl (
        .i_clk, .i_rst_n, .start, .i_word, .i_count(r_count), .i_status(status),
        .busy, .o_strobe, .o_is_read(is_read), .o_cmd(cmd)
    );

    vlp_datapath u_dp (
        .i_clk, .i_cmd(cmd), .i_word(r_word), .o_status(status), .o_data(data)
    );

    // Non-read commands report zero.
    assign o_word = is_read ? data : '0;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import vlp_pkg::*;

    localparam int CycleLimit = 20000000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_in_word          i_word = '0;
    logic              o_strobe;
    t_out_word         o_word;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CountW-1:0] i_cfg_data = '0;

    voxel_light_propagation dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_word     (i_word),
        .o_strobe   (o_strobe),
        .o_word     (o_word),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the chunk stores, kept in step with every accepted word.
    logic [7:0]        shadow_light [MaxChunks*TilesPerChunk];
    logic [7:0]        shadow_render[MaxChunks*TilesPerChunk];
    logic              shadow_clear [MaxChunks*TilesPerChunk];
    logic [SlotW-1:0]  shadow_link  [MaxChunks*6];
    logic [CountW-1:0] shadow_count;

    // Inner step and cross-border step for each face: -x, +x, -y, +y, -z, +z.
    const int inner_step[6]  = '{-1, 1, -4, 4, -16, 16};
    const int border_step[6] = '{3, -3, 12, -12, 48, -48};

    t_out_word pending_light[$];
    int        error_count = 0;
    int        cycle_count = 0;
    int        burst_left = 0;

    // Raise one transparent tile to the brightest half render light around it.
    function automatic logic [7:0] brightest_neighbor(int c, int t);
        int         base;
        int         src;
        int         o;
        logic [7:0] best;
        logic [7:0] v;
        base = c * TilesPerChunk;
        best = shadow_light[base + t];
        for (int f = 0; f < 6; f++) begin
            src = -1;
            if (((t >> (f & 6)) & 3) != ((f & 1) ? 3 : 0)) begin
                src = base + t + inner_step[f];
            end else begin
                o = shadow_link[c * 6 + f];
                if (o != 0 && o < MaxChunks)
                    src = o * TilesPerChunk + t + border_step[f];
            end
            if (src >= 0) begin
                v = shadow_render[src] >> 1;
                if (v > best)
                    best = v;
            end
        end
        return best;
    endfunction

    // Apply one command word to the shadow stores and return the light it reports.
    function automatic t_out_word apply_command(t_in_word w);
        t_out_word  r;
        int         lim;
        int         a;
        logic [7:0] raised[TilesPerChunk];
        r = '0;
        lim = (shadow_count > MaxChunks) ? MaxChunks : shadow_count;
        a = w.chunk_slot * TilesPerChunk + w.tile_index;
        case (w.kind)
            KIND_WRITE_TILE: begin
                shadow_light[a] = w.light_level;
                shadow_clear[a] = w.is_transparent;
            end
            KIND_WRITE_LINK: begin
                if (w.side < 6)
                    shadow_link[w.chunk_slot * 6 + w.side] = w.linked_chunk;
            end
            KIND_DECAY: begin
                for (int i = TilesPerChunk; i < lim * TilesPerChunk; i++) begin
                    shadow_render[i] = shadow_light[i];
                    shadow_light[i] = shadow_light[i] >> 1;
                end
            end
            KIND_SPREAD: begin
                // Neighbours are read from render light only, so tiles may be updated in place.
                for (int c = 1; c < lim; c++) begin
                    for (int t = 0; t < TilesPerChunk; t++)
                        raised[t] = shadow_clear[c * TilesPerChunk + t]
                                  ? brightest_neighbor(c, t)
                                  : shadow_light[c * TilesPerChunk + t];
                    for (int t = 0; t < TilesPerChunk; t++)
                        shadow_light[c * TilesPerChunk + t] = raised[t];
                end
            end
            KIND_READ: begin
                r.light_out  = shadow_light[a];
                r.render_out = shadow_render[a];
            end
            default: ;
        endcase
        return r;
    endfunction

    // Present one word on the command port and hold it until the block takes it.
    // Start is left high; the caller lowers it only when a gap follows.
    task automatic issue(t_in_word w, bit typed, t_out_word typed_light);
        t_out_word predicted;
        start  <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (busy);
        predicted = apply_command(w);
        pending_light.push_back(typed ? typed_light : predicted);
    endtask

    // Sender pacing: bursts of back-to-back words separated by random gaps.
    task automatic pace;
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Wait until every reported light word is back; the block is then idle.
    task automatic drain;
        start <= 1'b0;
        while (pending_light.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_chunk_count(logic [CountW-1:0] n);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= n;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow_count = n;
    endtask

    // Result monitor: every strobe must match the oldest pending light word.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_strobe) begin
            if (pending_light.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result light=%0d render=%0d",
                             o_word.light_out, o_word.render_out);
            end else begin
                want = pending_light.pop_front();
                if (o_word.light_out !== want.light_out ||
                    o_word.render_out !== want.render_out) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: light exp %0d got %0d, render exp %0d got %0d",
                                 want.light_out, o_word.light_out,
                                 want.render_out, o_word.render_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Directed rows: a row either sets the chunk count or sends one word.
    typedef struct {
        bit               is_cfg;
        logic [CountW-1:0] count;
        t_in_word          w;
        bit                typed;
        t_out_word         light;
    } t_row;

    function automatic t_in_word mk(t_kind k, int slot, int tile, int lvl,
                                    int tr, int sd, int lk);
        t_in_word w;
        w.kind = k;
        w.chunk_slot = SlotW'(slot);
        w.tile_index = TileW'(tile);
        w.light_level = 8'(lvl);
        w.is_transparent = 1'(tr);
        w.side = 3'(sd);
        w.linked_chunk = SlotW'(lk);
        return w;
    endfunction

    function automatic t_out_word lo(int l, int r);
        t_out_word o;
        o.light_out = 8'(l);
        o.render_out = 8'(r);
        return o;
    endfunction

    function automatic t_row cfg_row(int n);
        t_row r;
        r = '{1, CountW'(n), '0, 0, '0};
        return r;
    endfunction

    function automatic t_row word_row(t_in_word w, bit typed, t_out_word l);
        t_row r;
        r = '{0, '0, w, typed, l};
        return r;
    endfunction

    t_row directed[$];

    // Random word, mostly aimed at the chunks that the passes will touch.
    function automatic t_in_word random_word(int hot);
        t_in_word w;
        int       pick;
        w = '0;
        w.chunk_slot = SlotW'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                           : $urandom_range(0, hot));
        w.tile_index = TileW'($urandom_range(0, 63));
        w.light_level = 8'($urandom_range(0, 255));
        w.is_transparent = ($urandom_range(0, 3) != 0);
        w.side = 3'(($urandom_range(0, 7) == 0) ? $urandom_range(6, 7)
                                                : $urandom_range(0, 5));
        w.linked_chunk = SlotW'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                             : $urandom_range(0, hot));
        pick = $urandom_range(0, 99);
        if (pick < 40)       w.kind = KIND_WRITE_TILE;
        else if (pick < 55)  w.kind = KIND_WRITE_LINK;
        else if (pick < 61)  w.kind = KIND_DECAY;
        else if (pick < 68)  w.kind = KIND_SPREAD;
        else if (pick < 95)  w.kind = KIND_READ;
        else                 w.kind = t_kind'($urandom_range(5, 7));
        return w;
    endfunction

    initial begin
        int hot;
        int n;
        for (int i = 0; i < MaxChunks * TilesPerChunk; i++) begin
            shadow_light[i] = '0;
            shadow_render[i] = '0;
            shadow_clear[i] = 1'b0;
        end
        for (int i = 0; i < MaxChunks * 6; i++)
            shadow_link[i] = '0;
        shadow_count = 1;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reads after reset, storage extremes, ignored link sides, unknown kinds.
        directed.push_back(word_row(mk(KIND_READ, 0, 0, 0, 0, 0, 0), 1, lo(0, 0)));
        directed.push_back(word_row(mk(KIND_READ, 63, 63, 0, 0, 0, 0), 1, lo(0, 0)));
        directed.push_back(word_row(mk(KIND_WRITE_TILE, 63, 63, 255, 1, 7, 63), 1, lo(0, 0)));
        directed.push_back(word_row(mk(KIND_READ, 63, 63, 0, 0, 0, 0), 1, lo(255, 0)));
        directed.push_back(word_row(mk(KIND_WRITE_TILE, 0, 5, 200, 1, 0, 0), 1, lo(0, 0)));
        directed.push_back(word_row(mk(KIND_WRITE_TILE, 1, 0, 0, 1, 0, 0), 0, '0));
        directed.push_back(word_row(mk(KIND_WRITE_TILE, 1, 1, 128, 0, 0, 0), 0, '0));
        directed.push_back(word_row(mk(KIND_WRITE_LINK, 1, 0, 0, 0, 0, 63), 1, lo(0, 0)));
        directed.push_back(word_row(mk(KIND_WRITE_LINK, 1, 0, 0, 0, 6, 2), 1, lo(0, 0)));
        directed.push_back(word_row(mk(KIND_WRITE_LINK, 1, 0, 0, 0, 7, 2), 1, lo(0, 0)));
        directed.push_back(word_row(mk(KIND_WRITE_LINK, 63, 0, 0, 0, 5, 1), 1, lo(0, 0)));
        directed.push_back(word_row(mk(t_kind'(5), 1, 1, 255, 1, 5, 63), 1, lo(0, 0)));
        directed.push_back(word_row(mk(t_kind'(7), 63, 63, 255, 1, 7, 63), 1, lo(0, 0)));
        // A count of one leaves the passes idle.
        directed.push_back(word_row(mk(KIND_DECAY, 0, 0, 0, 0, 0, 0), 1, lo(0, 0)));
        directed.push_back(word_row(mk(KIND_READ, 1, 1, 0, 0, 0, 0), 1, lo(128, 0)));
        // Count of zero, then every chunk in use, then a count beyond the store.
        directed.push_back(cfg_row(0));
        directed.push_back(word_row(mk(KIND_SPREAD, 0, 0, 0, 0, 0, 0), 1, lo(0, 0)));
        directed.push_back(cfg_row(64));
        directed.push_back(word_row(mk(KIND_DECAY, 0, 0, 0, 0, 0, 0), 1, lo(0, 0)));
        directed.push_back(word_row(mk(KIND_SPREAD, 0, 0, 0, 0, 0, 0), 1, lo(0, 0)));
        directed.push_back(word_row(mk(KIND_READ, 63, 63, 0, 0, 0, 0), 1, lo(127, 255)));
        directed.push_back(word_row(mk(KIND_READ, 1, 0, 0, 0, 0, 0), 0, '0));
        directed.push_back(word_row(mk(KIND_READ, 0, 5, 0, 0, 0, 0), 1, lo(200, 0)));
        directed.push_back(cfg_row(127));
        directed.push_back(word_row(mk(KIND_DECAY, 0, 0, 0, 0, 0, 0), 1, lo(0, 0)));
        directed.push_back(word_row(mk(KIND_SPREAD, 0, 0, 0, 0, 0, 0), 1, lo(0, 0)));
        directed.push_back(word_row(mk(KIND_READ, 1, 1, 0, 0, 0, 0), 0, '0));

        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                set_chunk_count(directed[i].count);
            end else begin
                issue(directed[i].w, directed[i].typed, directed[i].light);
                pace();
            end
        end

        // Random phases, each with its own chunk count; small counts keep
        // passes short, with an occasional full or oversized count.
        for (int phase = 0; phase < 7; phase++) begin
            case ($urandom_range(0, 7))
                0:       n = $urandom_range(0, 1);
                1:       n = ($urandom_range(0, 1) == 0) ? 64 : $urandom_range(65, 127);
                default: n = $urandom_range(2, 6);
            endcase
            set_chunk_count(CountW'(n));
            hot = (n > 8) ? 8 : n;
            if (hot < 2)
                hot = 2;
            repeat (17) begin
                issue(random_word(hot), 0, '0);
                pace();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> voxel_light_propagation.f
rtl/core/vlp_pkg.sv
rtl/core/vlp_datapath.sv
rtl/core/vlp_controller.sv
rtl/core/voxel_light_propagation.sv
sim/tb_top.sv
